### rtl/rlfs_pkg.sv
// shared types, constants and helpers for the radio link failsafe block
`timescale 1ns / 1ps
`default_nettype none

package rlfs_pkg;

    localparam int TICK_WIDTH_DEF = 32;
    localparam int TICK_IN_W      = 32;
    localparam int STICK_W        = 16;
    localparam int OPND_W         = 17;
    localparam int PROD_W         = 2 * OPND_W;
    localparam int FRAC_BITS      = 15;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_ROLL_MAX   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_MAX  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOSS_TH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHUTDOWN_TH = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_YAW_ALPHA  = 3'd4;

    localparam logic [14:0] ROLL_MAX_RST    = 15'd5120;
    localparam logic [14:0] PITCH_MAX_RST   = 15'd5120;
    localparam logic [31:0] LOSS_TH_RST     = 32'd1500;
    localparam logic [31:0] SHUTDOWN_TH_RST = 32'd5000;
    localparam logic [15:0] YAW_ALPHA_RST   = 16'd6554;

    localparam logic signed [OPND_W-1:0] Q15_ONE = 17'sd32768;

    typedef enum logic {
        OP_PACKET = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef struct packed {
        logic               operation;
        logic [31:0]        tick_now;
        logic signed [15:0] throttle_stick;
        logic signed [15:0] roll_stick;
        logic signed [15:0] pitch_stick;
        logic signed [15:0] yaw_stick;
        logic               motor_switch;
    } in_item_t;

    typedef struct packed {
        logic               setpoint_valid;
        logic signed [15:0] throttle_out;
        logic signed [15:0] roll_degrees;
        logic signed [15:0] pitch_degrees;
        logic signed [15:0] yaw_out;
        logic               motor_toggle;
        logic               motor_off;
        logic               failsafe_phase;
    } out_item_t;

    typedef struct packed {
        logic [14:0] roll_max_angle;
        logic [14:0] pitch_max_angle;
        logic [31:0] loss_threshold;
        logic [31:0] shutdown_threshold;
        logic [15:0] yaw_curve_alpha;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROLL,
        ST_PITCH,
        ST_ALPHA,
        ST_YAW,
        ST_FINISH,
        ST_TICK
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ROLL,
        MUL_PITCH,
        MUL_ALPHA,
        MUL_YAW
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        logic     wb_roll;
        logic     wb_pitch;
        logic     commit_packet;
        logic     commit_tick;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

    // floor shift of a Q15 product, clamped to 16 bit signed
    function automatic logic signed [15:0] shr15_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        sh = p >>> FRAC_BITS;
        if (sh > 34'sd32767) begin
            shr15_sat = 16'sh7fff;
        end else if (sh < -34'sd32768) begin
            shr15_sat = 16'sh8000;
        end else begin
            shr15_sat = sh[15:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/rlfs_ctrl.sv
// sequencing state machine for the failsafe and stick shaping datapath
`timescale 1ns / 1ps
`default_nettype none

module rlfs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_op,
    output logic                  s_ready,
    input  rlfs_pkg::dp_sts_t     sts,
    output rlfs_pkg::dp_cmd_t     cmd
);
    import rlfs_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_op == OP_TICK) ? ST_TICK : ST_ROLL;
                end
            end
            ST_ROLL:   state_next = ST_PITCH;
            ST_PITCH:  state_next = ST_ALPHA;
            ST_ALPHA:  state_next = ST_YAW;
            ST_YAW:    state_next = ST_FINISH;
            ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        cmd.mul_sel = MUL_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_ROLL:  cmd.mul_sel = MUL_ROLL;
            ST_PITCH: begin
                cmd.mul_sel = MUL_PITCH;
                cmd.wb_roll = 1'b1;
            end
            ST_ALPHA: begin
                cmd.mul_sel  = MUL_ALPHA;
                cmd.wb_pitch = 1'b1;
            end
            ST_YAW:    cmd.mul_sel = MUL_YAW;
            ST_FINISH: cmd.commit_packet = sts.out_free;
            ST_TICK:   cmd.commit_tick = sts.out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/rlfs_datapath.sv
// link state, shared multiplier and result register
`timescale 1ns / 1ps
`default_nettype none

module rlfs_datapath #(
    parameter int TICK_WIDTH = rlfs_pkg::TICK_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  rlfs_pkg::cfg_t         cfg,
    input  rlfs_pkg::in_item_t     s_data,
    input  rlfs_pkg::dp_cmd_t      cmd,
    output rlfs_pkg::dp_sts_t      sts,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rlfs_pkg::out_item_t    m_data
);
    import rlfs_pkg::*;

    localparam int CMP_W = (TICK_WIDTH > TICK_IN_W) ? TICK_WIDTH : TICK_IN_W;

    in_item_t                  in_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [15:0]        roll_reg;
    logic signed [15:0]        pitch_reg;
    logic [TICK_WIDTH-1:0]     last_tick_reg;
    logic                      link_reg;
    logic                      failsafe_reg;
    logic                      held_reg;
    logic                      m_valid_reg;
    out_item_t                 out_reg;

    logic signed [OPND_W-1:0]  mul_a;
    logic signed [OPND_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [OPND_W-1:0]  yaw_ext;
    logic signed [OPND_W-1:0]  yaw_mag;
    logic [15:0]               curve_t;
    logic [TICK_WIDTH-1:0]     tick_ext;
    logic [TICK_WIDTH-1:0]     elapsed;
    logic                      past_loss;
    logic                      past_shutdown;
    logic                      out_free;

    assign out_free     = !m_valid_reg || m_ready;
    assign sts.out_free = out_free;

    // operand selection for the shared 17x17 signed multiplier
    assign yaw_ext = {in_reg.yaw_stick[15], in_reg.yaw_stick};
    assign yaw_mag = yaw_ext[OPND_W-1] ? -yaw_ext : yaw_ext;
    // t = (alpha * (1 - |s|)) >> 15, product is never negative
    assign curve_t = prod_reg[30:15];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_ROLL: begin
                mul_a = {in_reg.roll_stick[15], in_reg.roll_stick};
                mul_b = {2'b00, cfg.roll_max_angle};
            end
            MUL_PITCH: begin
                mul_a = {in_reg.pitch_stick[15], in_reg.pitch_stick};
                mul_b = {2'b00, cfg.pitch_max_angle};
            end
            MUL_ALPHA: begin
                mul_a = {1'b0, cfg.yaw_curve_alpha};
                mul_b = Q15_ONE - yaw_mag;
            end
            MUL_YAW: begin
                mul_a = yaw_ext;
                mul_b = Q15_ONE - $signed({1'b0, curve_t});
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // elapsed ticks since the last packet, wrapping at the tick width
    assign tick_ext      = TICK_WIDTH'(in_reg.tick_now);
    assign elapsed       = tick_ext - last_tick_reg;
    assign past_loss     = CMP_W'(elapsed) > CMP_W'(cfg.loss_threshold);
    assign past_shutdown = CMP_W'(elapsed) > CMP_W'(cfg.shutdown_threshold);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.mul_sel != MUL_NONE) begin
            prod_reg <= prod_next;
        end
        if (cmd.wb_roll) begin
            roll_reg <= shr15_sat(prod_reg);
        end
        if (cmd.wb_pitch) begin
            pitch_reg <= shr15_sat(prod_reg);
        end
        if (cmd.commit_packet) begin
            out_reg.setpoint_valid <= 1'b1;
            out_reg.throttle_out   <= in_reg.throttle_stick;
            out_reg.roll_degrees   <= roll_reg;
            out_reg.pitch_degrees  <= pitch_reg;
            out_reg.yaw_out        <= shr15_sat(prod_reg);
            out_reg.motor_toggle   <= !in_reg.motor_switch && held_reg;
            out_reg.motor_off      <= 1'b0;
            out_reg.failsafe_phase <= 1'b0;
        end else if (cmd.commit_tick) begin
            out_reg.setpoint_valid <= past_loss && link_reg && !past_shutdown;
            out_reg.throttle_out   <= '0;
            out_reg.roll_degrees   <= '0;
            out_reg.pitch_degrees  <= '0;
            out_reg.yaw_out        <= '0;
            out_reg.motor_toggle   <= 1'b0;
            out_reg.motor_off      <= past_loss && link_reg && past_shutdown;
            out_reg.failsafe_phase <= failsafe_reg || (past_loss && link_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_tick_reg <= '0;
            link_reg      <= 1'b0;
            failsafe_reg  <= 1'b0;
            held_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.commit_packet) begin
                last_tick_reg <= tick_ext;
                link_reg      <= 1'b1;
                failsafe_reg  <= 1'b0;
                held_reg      <= in_reg.motor_switch;
            end else if (cmd.commit_tick && past_loss && link_reg) begin
                failsafe_reg <= 1'b1;
                if (past_shutdown) begin
                    link_reg <= 1'b0;
                end
            end
            if (cmd.commit_packet || cmd.commit_tick) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

### rtl/radio_link_failsafe_and_stick_shaper_top.sv
// Radio link failsafe and stick shaper, top level.
//
// Input channel s_*: one request per received packet or per periodic tick
// check, valid/ready handshake. Result channel m_*: exactly one result per
// request, held in an output register until taken.
// Configuration: cfg_wr_en, cfg_addr, cfg_wdata write one register per cycle;
// write only while no request is in flight. Unknown addresses are ignored.
//
// A packet request steps through the roll, pitch, alpha, yaw and finish states
// before the next request can be accepted: the four Q15 products (roll, pitch,
// yaw curve, yaw) go one per cycle through a single 17x17 multiplier, then the
// result is committed once the output register is free. A tick check has only
// the tick state. m_valid rises when a result is committed.
// When the receiver stalls, one finished result waits in the output register
// and the next request is still accepted and worked on; it then holds at the
// commit step until the output register frees up.
// Reset (aresetn low, synchronous) restores default configuration, clears
// the link, failsafe and switch state and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module radio_link_failsafe_and_stick_shaper_top #(
    parameter int TICK_WIDTH = rlfs_pkg::TICK_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  rlfs_pkg::in_item_t                     s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output rlfs_pkg::out_item_t                    m_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [rlfs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [rlfs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import rlfs_pkg::*;

    cfg_t    cfg_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.roll_max_angle     <= ROLL_MAX_RST;
            cfg_reg.pitch_max_angle    <= PITCH_MAX_RST;
            cfg_reg.loss_threshold     <= LOSS_TH_RST;
            cfg_reg.shutdown_threshold <= SHUTDOWN_TH_RST;
            cfg_reg.yaw_curve_alpha    <= YAW_ALPHA_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ROLL_MAX:    cfg_reg.roll_max_angle     <= cfg_wdata[14:0];
                CFG_PITCH_MAX:   cfg_reg.pitch_max_angle    <= cfg_wdata[14:0];
                CFG_LOSS_TH:     cfg_reg.loss_threshold     <= cfg_wdata[31:0];
                CFG_SHUTDOWN_TH: cfg_reg.shutdown_threshold <= cfg_wdata[31:0];
                CFG_YAW_ALPHA:   cfg_reg.yaw_curve_alpha    <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    rlfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.operation),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rlfs_datapath #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // one request in flight at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // packet results never carry motor_off, tick results never toggle
    a_pulse_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.motor_toggle && m_data.motor_off))
        else $error("toggle and off pulses in one result");

    // shutdown implies failsafe with no setpoints
    a_shutdown_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.motor_off) |->
            (m_data.failsafe_phase && !m_data.setpoint_valid))
        else $error("motor off without failsafe");

    // a toggle pulse only comes from a packet, which leaves failsafe
    a_toggle_no_failsafe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.motor_toggle) |->
            (!m_data.failsafe_phase && m_data.setpoint_valid))
        else $error("toggle pulse in a failsafe result");

endmodule

`default_nettype wire

### verif/tb_radio_link_failsafe_and_stick_shaper_top.sv
// testbench for the radio link failsafe and stick shaper top level
`timescale 1ns / 1ps

module tb_radio_link_failsafe_and_stick_shaper_top;
    import rlfs_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_MAX    = 10;
    localparam int RECONFIG_EVERY = 64;
    localparam logic [CFG_ADDR_W-1:0] CFG_NO_REG = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // register mirror
    logic [14:0] cfg_roll;
    logic [14:0] cfg_pitch;
    logic [31:0] cfg_loss;
    logic [31:0] cfg_shut;
    logic [15:0] cfg_alpha;

    // link state mirror
    logic [31:0] exp_last_tick;
    logic        exp_link_up;
    logic        exp_failsafe;
    logic        exp_switch_held;

    out_item_t expected_link_results[$];
    out_item_t oldest_expected;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_request   = 1'b0;

    always #CLK_HALF aclk = ~aclk;

    radio_link_failsafe_and_stick_shaper_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    function automatic logic signed [15:0] clamp_q15(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // computes the result of one request and advances the link state mirror
    function automatic out_item_t predict_link_result(input in_item_t req);
        out_item_t   res;
        longint      yaw_s;
        longint      yaw_mag;
        longint      curve_t;
        longint      curve_f;
        logic [31:0] elapsed;
        res = '0;
        if (req.operation == OP_PACKET) begin
            exp_link_up   = 1'b1;
            exp_failsafe  = 1'b0;
            exp_last_tick = req.tick_now;
            if (req.motor_switch) begin
                exp_switch_held = 1'b1;
            end else if (exp_switch_held) begin
                res.motor_toggle = 1'b1;
                exp_switch_held  = 1'b0;
            end
            res.setpoint_valid = 1'b1;
            res.throttle_out   = req.throttle_stick;
            res.roll_degrees   = clamp_q15((longint'($signed(req.roll_stick))
                                            * longint'(cfg_roll)) >>> 15);
            res.pitch_degrees  = clamp_q15((longint'($signed(req.pitch_stick))
                                            * longint'(cfg_pitch)) >>> 15);
            yaw_s   = longint'($signed(req.yaw_stick));
            yaw_mag = (yaw_s < 0) ? -yaw_s : yaw_s;
            curve_t = (longint'(cfg_alpha) * (32768 - yaw_mag)) >>> 15;
            curve_f = 32768 - curve_t;
            res.yaw_out = clamp_q15((yaw_s * curve_f) >>> 15);
        end else begin
            elapsed = req.tick_now - exp_last_tick;
            if (elapsed > cfg_loss && exp_link_up) begin
                exp_failsafe = 1'b1;
                if (elapsed > cfg_shut) begin
                    res.motor_off = 1'b1;
                    exp_link_up   = 1'b0;
                end else begin
                    res.setpoint_valid = 1'b1;
                end
            end
        end
        res.failsafe_phase = exp_failsafe;
        return res;
    endfunction

    function automatic in_item_t make_packet(input logic [31:0] tick,
                                             input logic signed [15:0] thr,
                                             input logic signed [15:0] roll,
                                             input logic signed [15:0] pitch,
                                             input logic signed [15:0] yaw,
                                             input logic sw);
        in_item_t r;
        r                = '0;
        r.operation      = OP_PACKET;
        r.tick_now       = tick;
        r.throttle_stick = thr;
        r.roll_stick     = roll;
        r.pitch_stick    = pitch;
        r.yaw_stick      = yaw;
        r.motor_switch   = sw;
        return r;
    endfunction

    function automatic in_item_t make_tick(input logic [31:0] tick);
        in_item_t r;
        r           = '0;
        r.operation = OP_TICK;
        r.tick_now  = tick;
        return r;
    endfunction

    function automatic logic signed [15:0] random_stick();
        logic [31:0] raw;
        int          near_zero;
        raw       = $urandom;
        near_zero = $urandom_range(0, 64);
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'(near_zero - 32);
            default: return raw[15:0];
        endcase
    endfunction

    // elapsed times clustered around the two thresholds
    function automatic logic [31:0] pick_elapsed();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, cfg_loss);
            1:       return cfg_loss;
            2:       return cfg_loss + 32'd1;
            3:       return (cfg_shut > cfg_loss) ? $urandom_range(cfg_loss + 32'd1, cfg_shut)
                                                  : cfg_loss + 32'd1;
            4:       return cfg_shut;
            5:       return cfg_shut + 32'd1;
            6:       return raw;
            default: return (cfg_shut != 32'hffffffff)
                            ? $urandom_range(cfg_shut + 32'd1, 32'hffffffff) : raw;
        endcase
    endfunction

    function automatic in_item_t random_request();
        in_item_t    r;
        logic [31:0] raw;
        raw              = $urandom;
        r                = '0;
        r.throttle_stick = random_stick();
        r.roll_stick     = random_stick();
        r.pitch_stick    = random_stick();
        r.yaw_stick      = random_stick();
        r.motor_switch   = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 6) begin
            r.operation = OP_PACKET;
            r.tick_now  = ($urandom_range(0, 9) == 0) ? raw
                          : exp_last_tick + $urandom_range(0, 2000);
        end else begin
            r.operation = OP_TICK;
            r.tick_now  = exp_last_tick + pick_elapsed();
        end
        return r;
    endfunction

    task automatic send_request(input in_item_t req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        expected_link_results.push_back(predict_link_result(req));
    endtask

    // lets every request in flight finish so the block is idle
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (expected_link_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_ROLL_MAX:    cfg_roll  = value[14:0];
            CFG_PITCH_MAX:   cfg_pitch = value[14:0];
            CFG_LOSS_TH:     cfg_loss  = value;
            CFG_SHUTDOWN_TH: cfg_shut  = value;
            CFG_YAW_ALPHA:   cfg_alpha = value[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [31:0] roll, input logic [31:0] pitch,
                                  input logic [31:0] loss, input logic [31:0] shut,
                                  input logic [31:0] alpha);
        write_reg(CFG_ROLL_MAX, roll);
        write_reg(CFG_PITCH_MAX, pitch);
        write_reg(CFG_LOSS_TH, loss);
        write_reg(CFG_SHUTDOWN_TH, shut);
        write_reg(CFG_YAW_ALPHA, alpha);
    endtask

    task automatic write_random_regs();
        logic [31:0] loss;
        logic [31:0] shut;
        logic [31:0] alpha;
        loss  = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3000);
        shut  = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 8000);
        alpha = ($urandom_range(0, 9) == 0) ? $urandom_range(32769, 65535)
                                            : $urandom_range(0, 32768);
        write_all_regs($urandom_range(0, 23040), $urandom_range(0, 23040), loss, shut, alpha);
    endtask

    // default registers: stick extremes, switch release, both thresholds, tick wrap
    task automatic test_default_link();
        send_request(make_tick(32'd100));
        send_request(make_packet(32'd10, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1));
        send_request(make_packet(32'd20, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0));
        send_request(make_packet(32'd30, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_request(make_packet(32'd40, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b1));
        send_request(make_tick(32'd40 + 32'd1500));
        send_request(make_tick(32'd40 + 32'd1501));
        send_request(make_tick(32'd40 + 32'd5000));
        send_request(make_tick(32'd40 + 32'd5001));
        send_request(make_tick(32'd40 + 32'd9000));
        send_request(make_packet(32'hffffff00, 16'sd12345, -16'sd12345, 16'sd23456,
                                 -16'sd23456, 1'b0));
        send_request(make_tick(32'h00000100));
        send_request(make_tick(32'h000005e0));
    endtask

    // register extremes, yaw curve above one and an unknown register index
    task automatic test_register_extremes();
        wait_all_results();
        write_all_regs(32'd0, 32'd23040, 32'd0, 32'hffffffff, 32'd32768);
        send_request(make_packet(32'd1000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1));
        send_request(make_packet(32'd1000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0));
        send_request(make_tick(32'd1000));
        send_request(make_tick(32'd1001));
        wait_all_results();
        write_all_regs(32'd23040, 32'd0, 32'hffffffff, 32'd0, 32'd0);
        send_request(make_packet(32'd7, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1));
        send_request(make_tick(32'd6));
        wait_all_results();
        write_all_regs(32'd23040, 32'd23040, 32'd10, 32'd20, 32'hffff);
        write_reg(CFG_NO_REG, 32'hffffffff);
        send_request(make_packet(32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 1'b0));
        send_request(make_packet(32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0));
        send_request(make_packet(32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 1'b0));
        send_request(make_packet(32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 1'b0));
        send_request(make_tick(32'd25));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        wait_all_results();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i % RECONFIG_EVERY == 0) begin
                wait_all_results();
                write_random_regs();
            end
            send_request(random_request());
        end
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        wait_all_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        repeat (40) send_request(random_request());
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_link_results.size() == 0) begin
                if (mismatch_count < REPORT_MAX) begin
                    $display("unexpected result %h", m_data);
                end
                mismatch_count++;
            end else begin
                oldest_expected = expected_link_results.pop_front();
                if (m_data.setpoint_valid !== oldest_expected.setpoint_valid
                    || m_data.throttle_out !== oldest_expected.throttle_out
                    || m_data.roll_degrees !== oldest_expected.roll_degrees
                    || m_data.pitch_degrees !== oldest_expected.pitch_degrees
                    || m_data.yaw_out !== oldest_expected.yaw_out
                    || m_data.motor_toggle !== oldest_expected.motor_toggle
                    || m_data.motor_off !== oldest_expected.motor_off
                    || m_data.failsafe_phase !== oldest_expected.failsafe_phase) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("exp v%b thr %0d rl %0d pt %0d yw %0d tg %b off %b fs %b",
                                 oldest_expected.setpoint_valid, oldest_expected.throttle_out,
                                 oldest_expected.roll_degrees, oldest_expected.pitch_degrees,
                                 oldest_expected.yaw_out, oldest_expected.motor_toggle,
                                 oldest_expected.motor_off, oldest_expected.failsafe_phase);
                        $display("got v%b thr %0d rl %0d pt %0d yw %0d tg %b off %b fs %b",
                                 m_data.setpoint_valid, m_data.throttle_out,
                                 m_data.roll_degrees, m_data.pitch_degrees,
                                 m_data.yaw_out, m_data.motor_toggle,
                                 m_data.motor_off, m_data.failsafe_phase);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        cfg_roll        = ROLL_MAX_RST;
        cfg_pitch       = PITCH_MAX_RST;
        cfg_loss        = LOSS_TH_RST;
        cfg_shut        = SHUTDOWN_TH_RST;
        cfg_alpha       = YAW_ALPHA_RST;
        exp_last_tick   = '0;
        exp_link_up     = 1'b0;
        exp_failsafe    = 1'b0;
        exp_switch_held = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_link();
        test_register_extremes();
        test_random_traffic(0, 0, 260);
        test_random_traffic(56, 0, 260);
        test_random_traffic(0, 56, 260);
        test_random_traffic(23, 23, 230);
        test_output_backpressure();
        wait_all_results();

        if (mismatch_count == 0 && expected_link_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rlfs_pkg.sv
rtl/rlfs_ctrl.sv
rtl/rlfs_datapath.sv
rtl/radio_link_failsafe_and_stick_shaper_top.sv
verif/tb_radio_link_failsafe_and_stick_shaper_top.sv
